// ----- design/gdsm_pkg.sv -----
// Shared types and codes for the grouped DFA string matcher.
`timescale 1ns / 1ps

package gdsm_pkg;

    localparam int CMD_W   = 2;
    localparam int STATE_W = 6;
    localparam int SLOT_W  = 3;
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 21;

    localparam logic [CMD_W-1:0] CMD_WR_SLOT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_MARK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHAR    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END     = 2'd3;

    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ANY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INSIDE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OUTSIDE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [STATE_W-1:0] state_sel;
        logic [SLOT_W-1:0]  slot_sel;
        logic [KIND_W-1:0]  class_kind;
        logic [CHAR_W-1:0]  range_low;
        logic [CHAR_W-1:0]  range_high;
        logic [STATE_W-1:0] target_state;
        logic               final_flag;
        logic [CHAR_W-1:0]  char_code;
    } item_t;

    typedef struct packed {
        logic accepted;
        logic stopped_early;
    } result_t;

    typedef logic [STATE_W-1:0] cfg_t;

    typedef struct packed {
        logic slot_we;
        logic slot_re;
        logic mark_we;
        logic mark_re;
        logic mark_val;
    } tbl_ctl_t;

endpackage

// ----- design/gdsm_chan_if.sv -----
// Valid/ready channel carrying one item of a chosen payload type.
`timescale 1ns / 1ps

interface gdsm_chan_if #(parameter type payload_t = logic) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- design/gdsm_slot_match.sv -----
// Shared slot compare unit: does one transition slot take the character.
`timescale 1ns / 1ps

module gdsm_slot_match #(
    parameter int CW = 21
) (
    input  logic [gdsm_pkg::KIND_W-1:0] kind,
    input  logic [CW-1:0]               range_lo,
    input  logic [CW-1:0]               range_hi,
    input  logic [CW-1:0]               ch,
    output logic                        hit
);

    logic in_range;

    assign in_range = (ch >= range_lo) && (ch <= range_hi);

    always_comb
    begin
        case (kind)
            gdsm_pkg::KIND_ANY:     hit = 1'b1;
            gdsm_pkg::KIND_INSIDE:  hit = in_range;
            gdsm_pkg::KIND_OUTSIDE: hit = !in_range;
            default:                hit = 1'b0;
        endcase
    end

endmodule

// ----- design/gdsm_table.sv -----
// Transition slot memory and final mark memory, with clearing pass after reset.
`timescale 1ns / 1ps

module gdsm_table #(
    parameter int NUM_STATES      = 64,
    parameter int SLOTS_PER_STATE = 8,
    parameter int ENTRY_W         = 50,
    localparam int DEPTH          = NUM_STATES * SLOTS_PER_STATE,
    localparam int AW             = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int SW             = $clog2(NUM_STATES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gdsm_pkg::tbl_ctl_t   ctl,
    input  logic [AW-1:0]        slot_waddr,
    input  logic [ENTRY_W-1:0]   slot_wdata,
    input  logic [AW-1:0]        slot_raddr,
    output logic [ENTRY_W-1:0]   slot_rdata,
    input  logic [SW-1:0]        mark_widx,
    input  logic [SW-1:0]        mark_ridx,
    output logic                 mark_rdata,
    output logic                 busy
);

    logic [ENTRY_W-1:0] slot_mem [DEPTH];
    logic               mark_mem [NUM_STATES];

    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    logic          busy_reg;
    logic          busy_next;

    logic               slot_we;
    logic [AW-1:0]      slot_addr;
    logic [ENTRY_W-1:0] slot_data;
    logic               mark_we;
    logic [SW-1:0]      mark_addr;
    logic               mark_data;

    always_comb
    begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else
        begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    assign slot_we   = busy_reg || ctl.slot_we;
    assign slot_addr = busy_reg ? clr_reg : slot_waddr;
    assign slot_data = busy_reg ? '0 : slot_wdata;
    assign mark_we   = busy_reg ? (32'(clr_reg) < NUM_STATES) : ctl.mark_we;
    assign mark_addr = busy_reg ? SW'(clr_reg) : mark_widx;
    assign mark_data = busy_reg ? 1'b0 : ctl.mark_val;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_addr] <= slot_data;
        end
        if (ctl.slot_re)
        begin
            slot_rdata <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_addr] <= mark_data;
        end
        if (ctl.mark_re)
        begin
            mark_rdata <= mark_mem[mark_ridx];
        end
    end

    assign busy = busy_reg;

endmodule

// ----- design/grouped_dfa_string_matcher_unit.sv -----
// Top level of the grouped DFA string matcher: sequencer, state and result register.
`timescale 1ns / 1ps

// Usage:
//   item   : input channel; cmd selects a slot write, a final mark write, one
//            character of the string, or end of string.
//   result : one item per end of string: accepted, stopped_early.
//   cfg    : start_state, always ready; it takes effect at the next string end.
// Operation (S = SLOTS_PER_STATE):
//   character : slots are read in order from slot 1 until one matches; the string
//               is refused if all S miss or the state is out of range, and a
//               refused string is not scanned. One slot a cycle is read from the
//               slot memory into the shared compare.
//   end of string : the final mark is read, then the result is registered.
// Reset: state and start_state go to 0; a clearing pass then sweeps all
//   NUM_STATES * SLOTS_PER_STATE slot entries (512 by default), with item
//   ready low. Final marks are cleared in the same pass.
// Stall: a waiting result does not block writes or characters; a second end
//   of string waits in its final cycle until the result register is free.
module grouped_dfa_string_matcher_unit #(
    parameter int NUM_STATES      = 64,
    parameter int SLOTS_PER_STATE = 8,
    parameter int CHAR_BITS       = 21
) (
    input  logic        clk,
    input  logic        rst_n,
    gdsm_chan_if.sink   item,
    gdsm_chan_if.source result,
    gdsm_chan_if.sink   cfg
);

    localparam int CW      = (CHAR_BITS < gdsm_pkg::CHAR_W) ? CHAR_BITS : gdsm_pkg::CHAR_W;
    localparam int TW      = gdsm_pkg::STATE_W;
    localparam int ENTRY_W = gdsm_pkg::KIND_W + 2 * CW + TW;
    localparam int DEPTH   = NUM_STATES * SLOTS_PER_STATE;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW      = $clog2(NUM_STATES);
    localparam int CNT_W   = $clog2(SLOTS_PER_STATE + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_END} state_t;

    state_t                       state_reg, state_next;
    logic [TW-1:0]                cur_reg, cur_next;
    logic                         dead_reg, dead_next;
    logic [TW-1:0]                start_reg;
    logic [CW-1:0]                char_reg, char_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [CNT_W-1:0]             k_reg, k_next;
    logic                         end_ok_reg, end_ok_next;
    logic                         res_valid_reg, res_valid_next;
    gdsm_pkg::result_t            res_reg, res_next;

    gdsm_pkg::tbl_ctl_t           tbl_ctl;
    logic [AW-1:0]                slot_waddr;
    logic [ENTRY_W-1:0]           slot_wdata;
    logic [AW-1:0]                slot_raddr;
    logic [ENTRY_W-1:0]           slot_rdata;
    logic                         mark_rdata;
    logic                         tbl_busy;

    logic                         accept;
    logic                         cur_ok;
    logic [AW-1:0]                base_addr;
    logic                         wr_ok;
    logic                         hit;
    logic [gdsm_pkg::KIND_W-1:0]  rd_kind;
    logic [CW-1:0]                rd_lo;
    logic [CW-1:0]                rd_hi;
    logic [TW-1:0]                rd_target;
    logic                         res_free;

    assign item.ready = (state_reg == ST_IDLE) && !tbl_busy;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign cur_ok    = 32'(cur_reg) < NUM_STATES;
    assign base_addr = AW'(32'(SW'(cur_reg)) * SLOTS_PER_STATE);
    assign wr_ok     = (32'(item.data.state_sel) < NUM_STATES) &&
                       (32'(item.data.slot_sel) < SLOTS_PER_STATE);

    assign slot_waddr = AW'(32'(SW'(item.data.state_sel)) * SLOTS_PER_STATE +
                            32'(item.data.slot_sel));
    assign slot_wdata = {item.data.class_kind, CW'(item.data.range_low),
                         CW'(item.data.range_high), item.data.target_state};

    assign rd_target = slot_rdata[TW-1:0];
    assign rd_hi     = slot_rdata[TW +: CW];
    assign rd_lo     = slot_rdata[TW + CW +: CW];
    assign rd_kind   = slot_rdata[TW + 2 * CW +: gdsm_pkg::KIND_W];

    assign res_free  = !res_valid_reg || result.ready;

    gdsm_slot_match #(.CW(CW)) u_match (
        .kind     (rd_kind),
        .range_lo (rd_lo),
        .range_hi (rd_hi),
        .ch       (char_reg),
        .hit      (hit)
    );

    gdsm_table #(
        .NUM_STATES      (NUM_STATES),
        .SLOTS_PER_STATE (SLOTS_PER_STATE),
        .ENTRY_W         (ENTRY_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tbl_ctl),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata),
        .slot_raddr (slot_raddr),
        .slot_rdata (slot_rdata),
        .mark_widx  (SW'(item.data.state_sel)),
        .mark_ridx  (SW'(cur_reg)),
        .mark_rdata (mark_rdata),
        .busy       (tbl_busy)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        dead_next      = dead_reg;
        char_next      = char_reg;
        addr_next      = addr_reg;
        k_next         = k_reg;
        end_ok_next    = end_ok_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_next       = res_reg;
        tbl_ctl        = '0;
        tbl_ctl.mark_val = item.data.final_flag;
        slot_raddr     = base_addr;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.data.cmd)
                        gdsm_pkg::CMD_WR_SLOT:
                        begin
                            tbl_ctl.slot_we = wr_ok;
                        end
                        gdsm_pkg::CMD_WR_MARK:
                        begin
                            tbl_ctl.mark_we = 32'(item.data.state_sel) < NUM_STATES;
                        end
                        gdsm_pkg::CMD_CHAR:
                        begin
                            if (!dead_reg)
                            begin
                                if (!cur_ok)
                                begin
                                    dead_next = 1'b1;
                                end
                                else
                                begin
                                    tbl_ctl.slot_re = 1'b1;
                                    char_next  = CW'(item.data.char_code);
                                    addr_next  = base_addr + 1'b1;
                                    k_next     = CNT_W'(1);
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            tbl_ctl.mark_re = cur_ok;
                            end_ok_next     = cur_ok;
                            state_next      = ST_END;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                slot_raddr = addr_reg;
                if (hit)
                begin
                    cur_next   = rd_target;
                    state_next = ST_IDLE;
                end
                else if (k_reg == CNT_W'(SLOTS_PER_STATE))
                begin
                    dead_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    tbl_ctl.slot_re = 1'b1;
                    addr_next = addr_reg + 1'b1;
                    k_next    = k_reg + 1'b1;
                end
            end
            ST_END:
            begin
                if (res_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.accepted      = !dead_reg && end_ok_reg && mark_rdata;
                    res_next.stopped_early = dead_reg;
                    cur_next   = start_reg;
                    dead_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            dead_reg      <= 1'b0;
            start_reg     <= '0;
            char_reg      <= '0;
            addr_reg      <= '0;
            k_reg         <= '0;
            end_ok_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            dead_reg      <= dead_next;
            char_reg      <= char_next;
            addr_reg      <= addr_next;
            k_reg         <= k_next;
            end_ok_reg    <= end_ok_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
            if (cfg.valid && cfg.ready)
            begin
                start_reg <= cfg.data;
            end
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // scan counter stays within the slot row
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (k_reg >= CNT_W'(1)) &&
                                 (k_reg <= CNT_W'(SLOTS_PER_STATE)))
        else $error("slot scan counter out of range");

    // a refused string keeps its state for later characters
    a_dead_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.data.cmd == gdsm_pkg::CMD_CHAR && dead_reg |=>
            $stable(cur_reg) && dead_reg && state_reg == ST_IDLE)
        else $error("refused string changed state");

    // end of string returns to start and posts a result
    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_END && res_free |=>
            cur_reg == $past(start_reg) && !dead_reg && res_valid_reg)
        else $error("end of string did not restart automaton");

    // no result can appear during the clearing pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_busy |-> !res_valid_reg && state_reg == ST_IDLE)
        else $error("activity during clearing pass");

endmodule
